[hw/rtl/wsst_pkg.sv]
// ----------------------------------------------------------------------------
// wsst_pkg
// Shared types, constants and command codes of the weekly setpoint schedule.
// ----------------------------------------------------------------------------
`default_nettype none
package wsst_pkg;

  localparam int MaxEventsDefault = 16;
  localparam logic [7:0] SetpointReset = 8'd20;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] now_day;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic [2:0] entry_day;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [7:0] entry_setpoint;
    logic       entry_repeat;
    logic [3:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] setpoint;
    logic [4:0] entry_count;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] setpoint;
    logic       repeat_flag;
  } event_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic rd;
    logic capture_a;
    logic capture_b;
    logic wr_a;
    logic wr_b;
    logic wr_hold;
    logic wr_new;
    logic sel_nxt;
    logic cnt_inc;
    logic cnt_dec;
    logic set_sp;
    logic done;
  } ctl_t;

  // Key of an event, 3 bits of days ahead, hour and minute.
  function automatic logic [13:0] ev_key(input event_t e, input logic [2:0] nd,
                                         input logic [4:0] nh, input logic [5:0] nm);
    logic [4:0] diff;
    logic [2:0] days;
    diff = 5'd14 + {2'b0, e.day} - {2'b0, nd};
    days = (diff >= 5'd21) ? 3'd0 :
           (diff >= 5'd14) ? 3'(diff - 5'd14) :
           (diff >= 5'd7) ? 3'(diff - 5'd7) : diff[2:0];
    if (e.day == nd && (e.hour < nh || (e.hour == nh && e.minute < nm))) begin
      days = 3'd7;
    end
    return {days, e.hour, e.minute};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/wsst_datapath.sv]
// ----------------------------------------------------------------------------
// wsst_datapath
// Event memory, working registers, event count and setpoint register.
// ----------------------------------------------------------------------------
`default_nettype none
module wsst_datapath import wsst_pkg::*; #(
  parameter int MAX_EVENTS = MaxEventsDefault,
  localparam int AW = $clog2(MAX_EVENTS),
  localparam int CW = $clog2(MAX_EVENTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ctl_t          ctl,
  input  wire in_item_t      item,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [AW-1:0] wr_addr,
  output logic [CW-1:0]      count,
  output logic [7:0]         setpoint,
  output event_t             ev_a,
  output logic               a_gt_hold,
  output logic               head_match
);

  event_t mem [MAX_EVENTS];
  event_t rd_ev;
  event_t ev_b;
  event_t hold;
  in_item_t cur;
  event_t wr_data;

  always_comb begin
    if (ctl.wr_new) begin
      wr_data = '{day: cur.entry_day, hour: cur.entry_hour, minute: cur.entry_minute,
                  setpoint: cur.entry_setpoint, repeat_flag: cur.entry_repeat};
    end else if (ctl.wr_hold) begin
      wr_data = hold;
    end else if (ctl.wr_b) begin
      wr_data = ev_b;
    end else begin
      wr_data = ev_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_ev <= mem[rd_addr];
    end
    if (ctl.wr_a || ctl.wr_b || ctl.wr_hold || ctl.wr_new) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.load) begin
      cur <= item;
    end
    if (ctl.capture_a) begin
      ev_a <= rd_ev;
    end
    if (ctl.capture_b) begin
      ev_b <= rd_ev;
    end
    if (ctl.sel_nxt) begin
      hold <= rd_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      setpoint <= SetpointReset;
    end else begin
      if (ctl.cnt_inc) begin
        count <= count + CW'(1);
      end else if (ctl.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (ctl.set_sp) begin
        setpoint <= ev_a.setpoint;
      end
    end
  end

  assign a_gt_hold = ev_key(ev_a, cur.now_day, cur.now_hour, cur.now_minute) >
                     ev_key(hold, cur.now_day, cur.now_hour, cur.now_minute);
  assign head_match = ev_a.day == cur.now_day && ev_a.hour == cur.now_hour &&
                      ev_a.minute == cur.now_minute;

endmodule
`default_nettype wire

[hw/rtl/wsst_ctrl.sv]
// ----------------------------------------------------------------------------
// wsst_ctrl
// Sequencer for insert (insertion sort), delete, tick and head rotation.
// ----------------------------------------------------------------------------
`default_nettype none
module wsst_ctrl import wsst_pkg::*; #(
  parameter int MAX_EVENTS = MaxEventsDefault,
  localparam int AW = $clog2(MAX_EVENTS),
  localparam int CW = $clog2(MAX_EVENTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire in_item_t      item,
  input  wire logic [CW-1:0] count,
  input  wire event_t        ev_a,
  input  wire logic          a_gt_hold,
  input  wire logic          head_match,
  output ctl_t               ctl,
  output logic [AW-1:0]      rd_addr,
  output logic [AW-1:0]      wr_addr,
  output logic               busy,
  output logic               fired,
  output logic [1:0]         status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_ORD    = 4'd2;
  localparam logic [3:0] S_ORDW   = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_CMPW   = 4'd5;
  localparam logic [3:0] S_CMPD   = 4'd6;
  localparam logic [3:0] S_HEAD   = 4'd7;
  localparam logic [3:0] S_HEADW  = 4'd8;
  localparam logic [3:0] S_HEADD  = 4'd9;
  localparam logic [3:0] S_SHIFT  = 4'd10;
  localparam logic [3:0] S_SHIFTW = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;
  localparam logic [3:0] S_SHIFTB = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] cmd;
  logic [CW-1:0] i, i_next, j, j_next, k, k_next;
  logic       rot, rot_next, f_next;
  logic [1:0] st_next;
  logic       item_sec_zero;
  logic [5:0] sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fired <= 1'b0;
      status <= ST_OK;
    end else begin
      state <= state_next;
      fired <= f_next;
      status <= st_next;
    end
    if (state == S_IDLE && start) begin
      cmd <= item.cmd;
    end
    i <= i_next;
    j <= j_next;
    k <= k_next;
    rot <= rot_next;
  end

  assign busy = state != S_IDLE;

  // rot: shifting for a rotation (move head to end) vs a delete.
  always_comb begin
    ctl = '0;
    state_next = state;
    i_next = i;
    j_next = j;
    k_next = k;
    rot_next = rot;
    f_next = 1'b0;
    st_next = status;
    rd_addr = '0;
    wr_addr = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          ctl.rd = 1'b1;
          state_next = S_DISP;
          k_next = CW'(item.entry_index);
        end
      end
      S_DISP: begin
        ctl.capture_a = 1'b1;
        st_next = ST_OK;
        case (cmd)
          CMD_INSERT: begin
            if (count >= CW'(MAX_EVENTS)) begin
              st_next = ST_FULL;
              state_next = S_DONE;
            end else begin
              ctl.wr_new = 1'b1;
              wr_addr = AW'(count);
              ctl.cnt_inc = 1'b1;
              i_next = CW'(1);
              state_next = S_ORD;
            end
          end
          CMD_DELETE: begin
            if (k >= count) begin
              st_next = ST_INDEX;
              state_next = S_DONE;
            end else begin
              rot_next = 1'b0;
              j_next = k;
              ctl.cnt_dec = 1'b1;
              state_next = S_SHIFT;
            end
          end
          CMD_TICK: begin
            state_next = S_HEAD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ORD: begin
        if (i >= count) begin
          ctl.rd = 1'b1;
          rd_addr = '0;
          state_next = S_HEADW;
        end else begin
          ctl.rd = 1'b1;
          rd_addr = AW'(i);
          j_next = i;
          state_next = S_ORDW;
        end
      end
      S_ORDW: begin
        ctl.sel_nxt = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (j == '0) begin
          ctl.wr_hold = 1'b1;
          wr_addr = '0;
          i_next = i + CW'(1);
          state_next = S_ORD;
        end else begin
          ctl.rd = 1'b1;
          rd_addr = AW'(j - CW'(1));
          state_next = S_CMPW;
        end
      end
      S_CMPW: begin
        ctl.capture_a = 1'b1;
        state_next = S_CMPD;
      end
      S_CMPD: begin
        if (a_gt_hold) begin
          ctl.wr_a = 1'b1;
          wr_addr = AW'(j);
          j_next = j - CW'(1);
          state_next = S_CMP;
        end else begin
          ctl.wr_hold = 1'b1;
          wr_addr = AW'(j);
          i_next = i + CW'(1);
          state_next = S_ORD;
        end
      end
      S_HEADW: begin
        ctl.capture_a = 1'b1;
        state_next = S_HEADD;
      end
      S_HEADD: begin
        if (count > CW'(1) && ev_a.repeat_flag && head_match) begin
          rot_next = 1'b1;
          j_next = '0;
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_HEAD: begin
        if (count != '0 && item_sec_zero && head_match) begin
          f_next = 1'b1;
          ctl.set_sp = 1'b1;
          j_next = '0;
          if (ev_a.repeat_flag) begin
            rot_next = 1'b1;
            state_next = (count > CW'(1)) ? S_SHIFT : S_DONE;
          end else begin
            rot_next = 1'b0;
            ctl.cnt_dec = 1'b1;
            state_next = S_SHIFT;
          end
          ctl.done = 1'b0;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        f_next = fired;
        if (rot ? (j + CW'(1) >= count) : (j >= count)) begin
          if (rot) begin
            ctl.wr_a = 1'b1;
            wr_addr = AW'(count - CW'(1));
          end
          state_next = S_DONE;
        end else begin
          ctl.rd = 1'b1;
          rd_addr = AW'(j + CW'(1));
          state_next = S_SHIFTW;
        end
      end
      S_SHIFTW: begin
        f_next = fired;
        ctl.capture_b = 1'b1;
        state_next = S_SHIFTB;
      end
      S_SHIFTB: begin
        f_next = fired;
        ctl.wr_b = 1'b1;
        wr_addr = AW'(j);
        j_next = j + CW'(1);
        state_next = S_SHIFT;
      end
      S_DONE: begin
        f_next = fired;
        ctl.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      sec <= item.now_second;
    end
  end
  assign item_sec_zero = sec == 6'd0;

endmodule
`default_nettype wire

[hw/rtl/weekly_setpoint_schedule_table.sv]
// ----------------------------------------------------------------------------
// weekly_setpoint_schedule_table
// Weekly event table kept in order of next occurrence, with setpoint output.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. The
// block then works on it alone and raises done for exactly one cycle with
// the result; the receiver cannot hold a result off, so nothing ever stalls.
// Busy is high from the cycle after acceptance through the done cycle, and
// the next transaction can be taken in the cycle after done.
// A no-op or a rejected command goes from dispatch straight to done, and a
// tick that does not fire passes through the head check first. Delete and
// a firing tick move each entry through the shift read, capture and write
// states. An insert re-sorts the table by insertion sort through the event
// memory, one read or write per state: each entry passes the order read and
// hold states and each compare the read, capture and decide states, and the
// head is then checked for rotation.
// Reset clears the count and sets the setpoint to 20; the event memory
// holds no reset value and needs none since only entries below the count
// are used.
// ----------------------------------------------------------------------------
`default_nettype none
module weekly_setpoint_schedule_table import wsst_pkg::*; #(
  parameter int MAX_EVENTS = MaxEventsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output logic           busy,
  output logic           done,
  output out_item_t      out_item
);

  localparam int AW = $clog2(MAX_EVENTS);
  localparam int CW = $clog2(MAX_EVENTS + 1);

  ctl_t          ctl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] count;
  logic [7:0]    setpoint;
  event_t        ev_a;
  logic          a_gt_hold, head_match, fired;
  logic [1:0]    status;

  wsst_ctrl #(.MAX_EVENTS(MAX_EVENTS)) u_ctrl (
    .clk, .rst, .start, .item(in_item), .count, .ev_a, .a_gt_hold, .head_match,
    .ctl, .rd_addr, .wr_addr, .busy, .fired, .status
  );

  wsst_datapath #(.MAX_EVENTS(MAX_EVENTS)) u_dp (
    .clk, .rst, .ctl, .item(in_item), .rd_addr, .wr_addr, .count, .setpoint,
    .ev_a, .a_gt_hold, .head_match
  );

  assign done = ctl.done;
  assign out_item.fired = fired;
  assign out_item.setpoint = setpoint;
  assign out_item.entry_count = 5'(count);
  assign out_item.status = status;

endmodule
`default_nettype wire
